// ===== rtl/ptn_pkg.sv =====
package ptn_pkg;

  // Result queue geometry.
  localparam int ResDepth = 4;
  localparam int PtrW     = $clog2(ResDepth);
  localparam int CntW     = $clog2(ResDepth) + 1;

  // ASCII characters that the block produces or tests for.
  localparam logic [6:0] ChApos   = 7'h27;
  localparam logic [6:0] ChA      = 7'h61;
  localparam logic [6:0] ChE      = 7'h65;
  localparam logic [6:0] ChI      = 7'h69;
  localparam logic [6:0] ChM      = 7'h6D;
  localparam logic [6:0] ChN      = 7'h6E;
  localparam logic [6:0] ChO      = 7'h6F;
  localparam logic [6:0] ChU      = 7'h75;
  localparam logic [6:0] ChV      = 7'h76;
  localparam logic [6:0] ChNone   = 7'h00;
  localparam logic [7:0] BytApos  = 8'h27;
  localparam logic [7:0] BytHyph  = 8'h2D;
  localparam logic [7:0] BytSpace = 8'h20;
  localparam logic [7:0] BytHt    = 8'h09;
  localparam logic [7:0] BytCr    = 8'h0D;
  localparam logic [7:0] BytUpA   = 8'h41;
  localparam logic [7:0] BytUpZ   = 8'h5A;
  localparam logic [7:0] BytLoA   = 8'h61;
  localparam logic [7:0] BytLoZ   = 8'h7A;

  // One result item.
  typedef struct packed {
    logic [6:0] chr;
    logic       chr_valid;
    logic       term_end;
    logic       run_last;
  } res_t;

  // Results caused by one accepted byte: up to two, first in res_a.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res_a;
    res_t       res_b;
  } push_t;

  // Plain letter for a tone-marked code point, or ChNone when it is not in the table.
  function automatic logic [6:0] marked_plain(input logic [15:0] cp);
    logic [6:0] c;
    case (cp)
      16'h0101, 16'h00E1, 16'h01CE, 16'h00E0: c = ChA;
      16'h0113, 16'h00E9, 16'h011B, 16'h00E8: c = ChE;
      16'h012B, 16'h00ED, 16'h01D0, 16'h00EC: c = ChI;
      16'h014D, 16'h00F3, 16'h01D2, 16'h00F2: c = ChO;
      16'h016B, 16'h00FA, 16'h01D4, 16'h00F9: c = ChU;
      16'h01D6, 16'h01D8, 16'h01DA, 16'h01DC, 16'h00FC: c = ChV;
      16'h0144, 16'h0148, 16'h01F9: c = ChN;
      16'h1E3F: c = ChM;
      default: c = ChNone;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ptn_decode.sv =====
module ptn_decode import ptn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_term_last,
  output push_t      push
);

  logic       sep_pending_r, sep_pending_nxt;
  logic       emitted_any_r, emitted_any_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] need_r, need_nxt;

  logic       cont;
  logic [15:0] cp;
  logic [6:0] letter;
  logic       apos;

  assign cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    if (held0_r[7:5] == 3'b110) begin
      cp = {5'b0, held0_r[4:0], in_byte[5:0]};
    end else if (held0_r[7:4] == 4'hE) begin
      cp = {held0_r[3:0], held1_r[5:0], in_byte[5:0]};
    end else begin
      cp = 16'h0000;
    end
  end

  always_comb begin
    sep_pending_nxt = sep_pending_r;
    emitted_any_nxt = emitted_any_r;
    held0_nxt       = held0_r;
    held1_nxt       = held1_r;
    need_nxt        = need_r;
    letter          = ChNone;
    if (need_r != 2'd0 && cont) begin
      if (need_r == 2'd2 && held0_r[7:4] == 4'hE) begin
        held1_nxt = in_byte;
      end
      need_nxt = need_r - 2'd1;
      if (need_r == 2'd1) begin
        // A four-byte lead decodes to no code point, so it falls out as unknown.
        letter    = (cp == 16'h0000) ? ChNone : marked_plain(cp);
        held0_nxt = 8'h00;
        held1_nxt = 8'h00;
      end
    end else begin
      if (need_r != 2'd0) begin
        held0_nxt = 8'h00;
        held1_nxt = 8'h00;
        need_nxt  = 2'd0;
      end
      if (in_byte >= BytUpA && in_byte <= BytUpZ) begin
        letter = in_byte[6:0] | 7'h20;
      end else if (in_byte >= BytLoA && in_byte <= BytLoZ) begin
        letter = in_byte[6:0];
      end else if (in_byte == BytApos || in_byte == BytHyph || in_byte == BytSpace ||
                   (in_byte >= BytHt && in_byte <= BytCr)) begin
        sep_pending_nxt = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        held0_nxt = in_byte;
        need_nxt  = 2'd1;
      end else if (in_byte[7:4] == 4'hE) begin
        held0_nxt = in_byte;
        need_nxt  = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        held0_nxt = in_byte;
        need_nxt  = 2'd3;
      end
    end

    apos = 1'b0;
    if (letter != ChNone) begin
      apos            = sep_pending_r && emitted_any_r;
      sep_pending_nxt = 1'b0;
      emitted_any_nxt = 1'b1;
    end

    if (letter == ChNone) begin
      // Only a final byte with no characters yields a bare end mark.
      push.cnt   = in_term_last ? 2'd1 : 2'd0;
      push.res_a = '{chr: ChNone, chr_valid: 1'b0, term_end: 1'b1, run_last: 1'b1};
    end else if (apos) begin
      push.cnt   = 2'd2;
      push.res_a = '{chr: ChApos, chr_valid: 1'b1, term_end: 1'b0, run_last: 1'b0};
    end else begin
      push.cnt   = 2'd1;
      push.res_a = '{chr: letter, chr_valid: 1'b1, term_end: in_term_last, run_last: 1'b1};
    end
    push.res_b = '{chr: letter, chr_valid: 1'b1, term_end: in_term_last, run_last: 1'b1};

    if (in_term_last) begin
      sep_pending_nxt = 1'b0;
      emitted_any_nxt = 1'b0;
      held0_nxt       = 8'h00;
      held1_nxt       = 8'h00;
      need_nxt        = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_pending_r <= 1'b0;
      emitted_any_r <= 1'b0;
      held0_r       <= 8'h00;
      held1_r       <= 8'h00;
      need_r        <= 2'd0;
    end else if (accept) begin
      sep_pending_r <= sep_pending_nxt;
      emitted_any_r <= emitted_any_nxt;
      held0_r       <= held0_nxt;
      held1_r       <= held1_nxt;
      need_r        <= need_nxt;
    end
  end

endmodule

// ===== rtl/ptn_result_fifo.sv =====
module ptn_result_fifo import ptn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_en,
  input  push_t push,
  output logic  full2,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  res_t            mem_r [ResDepth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      n_push;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign n_push    = push_en ? push.cnt : 2'd0;
  // Accept only while two free slots remain, so a two-result byte always fits.
  assign full2     = (cnt_r > CntW'(ResDepth - 2));

  always_comb begin
    wr_nxt  = wr_r + PtrW'(n_push);
    rd_nxt  = rd_r + PtrW'(pop);
    cnt_nxt = cnt_r + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= push.res_a;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + PtrW'(1)] <= push.res_b;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(ResDepth))
    else $error("result queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> !full2)
    else $error("push into result queue without room for two");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.term_end) |-> out_res.run_last)
    else $error("term end result is not the last of its byte");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && push.cnt == 2'd2) |=> (mem_r[$past(wr_r)].chr == ChApos &&
                                       !mem_r[$past(wr_r)].run_last))
    else $error("two-result byte did not queue separator first");

endmodule

// ===== rtl/pinyin_text_normalizer_top.sv =====
// The results of each accepted byte are written into the result queue and read out from there.
// Throughput: one byte per cycle; a byte that yields a separator and a letter
// puts two results into the queue, and the input stalls only when the four-entry
// result queue has fewer than two free slots.
// Reset: synchronous, active low; clears the term state and empties the queue.
module pinyin_text_normalizer_top import ptn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_term_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_char_valid,
  output logic       out_term_end,
  output logic       out_run_last
);

  // The decoder holds the per-term state (pending separator, whether a letter
  // has gone out, and any partly received multibyte sequence). It turns each
  // accepted request into zero, one or two results in the same cycle.
  logic  accept;
  logic  full2;
  push_t push;
  res_t  out_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = full2;

  ptn_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_term_last (in_term_last),
    .push         (push)
  );

  // The result queue separates the two sides, so new requests keep flowing while
  // earlier results wait for the consumer, as long as two slots are free.
  ptn_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push      (push),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_char       = out_res.chr;
  assign out_char_valid = out_res.chr_valid;
  assign out_term_end   = out_res.term_end;
  assign out_run_last   = out_res.run_last;

endmodule

// ===== dv/pinyin_text_normalizer_top_test.sv =====
module pinyin_text_normalizer_top_test;
  import ptn_pkg::*;

  // Tone-marked code points and the plain letter each one folds to, listed in
  // matching order with the first entry in the most significant position.
  localparam int TONE_COUNT = 29;
  localparam logic [TONE_COUNT*16-1:0] TONE_CPS = {
    16'h0101, 16'h00E1, 16'h01CE, 16'h00E0,
    16'h0113, 16'h00E9, 16'h011B, 16'h00E8,
    16'h012B, 16'h00ED, 16'h01D0, 16'h00EC,
    16'h014D, 16'h00F3, 16'h01D2, 16'h00F2,
    16'h016B, 16'h00FA, 16'h01D4, 16'h00F9,
    16'h01D6, 16'h01D8, 16'h01DA, 16'h01DC, 16'h00FC,
    16'h0144, 16'h0148, 16'h01F9, 16'h1E3F
  };
  localparam logic [TONE_COUNT*8-1:0] TONE_LETTERS = "aaaaeeeeiiiioooouuuuvvvvvnnnm";

  // Opening requests: two hand-written terms. The first mixes capitals, a
  // separator in front of a two-byte mark, a three-byte mark, a hyphen, a stray
  // continuation byte, a digit and a final 0xFF that yields nothing, so the term
  // closes with a bare end mark. The second opens with a separator before any
  // letter, then has a broken sequence, a sequence that is not in the table, a
  // four-byte sequence, a zero byte, and ends in the middle of a sequence.
  localparam int OPENING_COUNT = 28;
  localparam logic [OPENING_COUNT*8-1:0] OPENING_BYTES = {
    8'h5A, 8'h41, 8'h20, 8'hC7, 8'h9C, 8'hE1, 8'hB8, 8'hBF,
    8'h2D, 8'h80, 8'h27, 8'h7A, 8'h35, 8'hFF,
    8'h0D, 8'h61, 8'hC3, 8'h62, 8'hC3, 8'hA4, 8'hF0, 8'h9F,
    8'h98, 8'h80, 8'h00, 8'h09, 8'hE1, 8'hB8
  };
  localparam logic [OPENING_COUNT-1:0] OPENING_LAST = 28'h0004001;

  localparam int RANDOM_REQS = 1250;
  localparam int CYCLE_LIMIT = 100000;
  localparam int IDLE_PCT    = 23;
  // Window of cycles in which neither side idles.
  localparam int CALM_FROM   = 400;
  localparam int CALM_TO     = 800;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_term_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  logic       out_char_valid;
  logic       out_term_end;
  logic       out_run_last;

  // Requests waiting to be driven, and the characters the block owes us.
  byte_req_t byte_reqs[$];
  res_t      want_chars[$];
  byte_req_t next_req;

  int  cycle_count = 0;
  int  mismatches = 0;
  wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  // Our own copy of the term state: a pending separator, whether a letter has
  // gone out in this term, the held sequence bytes and how many are missing.
  logic       sep_seen = 1'b0;
  logic       letter_out = 1'b0;
  logic [7:0] lead_b = 8'h00;
  logic [7:0] mid_b = 8'h00;
  logic [1:0] cont_left = 2'd0;

  // Characters produced by the request being predicted.
  logic [6:0] step_chr[2];
  int         step_n;

  pinyin_text_normalizer_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_term_last   (in_term_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_term_end   (out_term_end),
    .out_run_last   (out_run_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Plain letter for a code point, or ChNone when the code point is not a
  // known tone mark.
  function automatic logic [6:0] tone_letter(input logic [15:0] cp);
    logic [6:0] c;
    int         i;
    c = ChNone;
    for (i = 0; i < TONE_COUNT; i++) begin
      if (TONE_CPS[(TONE_COUNT-1-i)*16 +: 16] == cp) begin
        c = TONE_LETTERS[(TONE_COUNT-1-i)*8 +: 7];
      end
    end
    return c;
  endfunction

  // A letter goes out, preceded by an apostrophe when a separator is pending
  // and an earlier letter of this term has already gone out.
  task automatic add_letter(input logic [6:0] c);
    if (sep_seen && letter_out && step_n < 2) begin
      step_chr[step_n] = ChApos;
      step_n++;
    end
    if (step_n < 2) begin
      step_chr[step_n] = c;
      step_n++;
    end
    sep_seen = 1'b0;
    letter_out = 1'b1;
  endtask

  // A byte seen with no multibyte sequence in progress.
  task automatic plain_byte(input logic [7:0] b);
    if (b >= BytUpA && b <= BytUpZ) begin
      add_letter(b[6:0] + 7'h20);
    end else if (b >= BytLoA && b <= BytLoZ) begin
      add_letter(b[6:0]);
    end else if (b == BytApos || b == BytHyph || b == BytSpace ||
                 (b >= BytHt && b <= BytCr)) begin
      sep_seen = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      lead_b = b;
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      lead_b = b;
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      lead_b = b;
      cont_left = 2'd3;
    end
  endtask

  // Works out the characters that one accepted request causes and queues them.
  task automatic normalize_byte(input logic [7:0] b, input logic last);
    logic [6:0] c;
    res_t       r;
    int         k;
    step_n = 0;
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        if (cont_left == 2'd2 && lead_b[7:4] == 4'b1110) begin
          mid_b = b;
        end
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          c = ChNone;
          if (lead_b[7:5] == 3'b110) begin
            c = tone_letter({5'b00000, lead_b[4:0], b[5:0]});
          end else if (lead_b[7:4] == 4'b1110) begin
            c = tone_letter({lead_b[3:0], mid_b[5:0], b[5:0]});
          end
          lead_b = 8'h00;
          mid_b = 8'h00;
          if (c != ChNone) begin
            add_letter(c);
          end
        end
      end else begin
        // The sequence is abandoned and the byte starts afresh.
        lead_b = 8'h00;
        mid_b = 8'h00;
        cont_left = 2'd0;
        plain_byte(b);
      end
    end else begin
      plain_byte(b);
    end
    for (k = 0; k < step_n; k++) begin
      r.chr = step_chr[k];
      r.chr_valid = 1'b1;
      r.term_end = last && (k == step_n - 1);
      r.run_last = (k == step_n - 1);
      want_chars.insert(want_chars.size(), r);
    end
    if (last) begin
      if (step_n == 0) begin
        r.chr = ChNone;
        r.chr_valid = 1'b0;
        r.term_end = 1'b1;
        r.run_last = 1'b1;
        want_chars.insert(want_chars.size(), r);
      end
      sep_seen = 1'b0;
      letter_out = 1'b0;
      lead_b = 8'h00;
      mid_b = 8'h00;
      cont_left = 2'd0;
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Cycle counter and the overall time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pinyin_text_normalizer_top_test: FAIL");
      $finish;
    end
  end

  // Driver. A request that was accepted at this edge goes to the predictor.
  // A new request is put up only when nothing is held, so a stalled request
  // never changes, and valid is decided without looking at the stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        normalize_byte(in_byte, in_term_last);
      end
      if (!in_valid || !in_stall) begin
        if (byte_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = byte_reqs.pop_front();
          in_valid <= 1'b1;
          in_byte <= next_req.data;
          in_term_last <= next_req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted result is held against the oldest character still
  // owed, field by field. The stall toward the block is chosen here as well.
  always @(posedge clk) begin : watch
    res_t want;
    if (out_valid && !out_stall) begin
      if (want_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected result char %02h valid %0b end %0b last %0b",
                                out_char, out_char_valid, out_term_end, out_run_last));
      end else begin
        want = want_chars.pop_front();
        if (out_char !== want.chr) begin
          note_mismatch($sformatf("out_char %02h, expected %02h", out_char, want.chr));
        end
        if (out_char_valid !== want.chr_valid) begin
          note_mismatch($sformatf("out_char_valid %0b, expected %0b",
                                  out_char_valid, want.chr_valid));
        end
        if (out_term_end !== want.term_end) begin
          note_mismatch($sformatf("out_term_end %0b, expected %0b",
                                  out_term_end, want.term_end));
        end
        if (out_run_last !== want.run_last) begin
          note_mismatch($sformatf("out_run_last %0b, expected %0b",
                                  out_run_last, want.run_last));
        end
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Stimulus and end of run. All requests are queued up front; the driver
  // drains the queue once reset is released.
  initial begin : stimulus
    logic [7:0]  term_bytes[$];
    logic [15:0] cp;
    logic [7:0]  b;
    int          term_len;
    int          pick;
    int          i;
    int          t;
    int          n;

    for (i = 0; i < OPENING_COUNT; i++) begin
      byte_reqs.insert(byte_reqs.size(), {OPENING_BYTES[(OPENING_COUNT-1-i)*8 +: 8],
                                          OPENING_LAST[OPENING_COUNT-1-i]});
    end

    // Random terms. Most pieces are well formed: letters, tone marks and
    // separators. The rest are loose bytes and sequences that are cut short,
    // too long, or simply not in the table.
    while (byte_reqs.size() < OPENING_COUNT + RANDOM_REQS) begin
      term_len = $urandom_range(1, 10);
      term_bytes.delete();
      for (t = 0; t < term_len; t++) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          b = BytLoA + 8'($urandom_range(25));
          if ($urandom_range(3) == 0) begin
            b = b - 8'h20;
          end
          term_bytes.insert(term_bytes.size(), b);
        end else if (pick < 55) begin
          n = $urandom_range(TONE_COUNT - 1);
          cp = TONE_CPS[n*16 +: 16];
          if (cp < 16'h0800) begin
            term_bytes.insert(term_bytes.size(), {3'b110, cp[10:6]});
          end else begin
            term_bytes.insert(term_bytes.size(), {4'b1110, cp[15:12]});
            term_bytes.insert(term_bytes.size(), {2'b10, cp[11:6]});
          end
          term_bytes.insert(term_bytes.size(), {2'b10, cp[5:0]});
        end else if (pick < 70) begin
          case ($urandom_range(3))
            0: term_bytes.insert(term_bytes.size(), BytApos);
            1: term_bytes.insert(term_bytes.size(), BytHyph);
            2: term_bytes.insert(term_bytes.size(), BytSpace);
            default: term_bytes.insert(term_bytes.size(), BytHt + 8'($urandom_range(4)));
          endcase
        end else if (pick < 80) begin
          term_bytes.insert(term_bytes.size(), 8'($urandom_range(255)));
        end else begin
          term_bytes.insert(term_bytes.size(), 8'($urandom_range(8'hC0, 8'hF7)));
          n = $urandom_range(3);
          for (i = 0; i < n; i++) begin
            term_bytes.insert(term_bytes.size(), {2'b10, 6'($urandom_range(63))});
          end
        end
      end
      for (i = 0; i < term_bytes.size(); i++) begin
        byte_reqs.insert(byte_reqs.size(), {term_bytes[i], i == term_bytes.size() - 1});
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Checked between edges, once the driver and the monitor have settled.
    while (byte_reqs.size() != 0 || in_valid || want_chars.size() != 0) @(negedge clk);
    // A further wait catches any result that should not be there.
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("pinyin_text_normalizer_top_test: PASS");
    end else begin
      $display("pinyin_text_normalizer_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptn_pkg.sv
rtl/ptn_decode.sv
rtl/ptn_result_fifo.sv
rtl/pinyin_text_normalizer_top.sv
dv/pinyin_text_normalizer_top_test.sv
